// ===== design/lsat_pkg.sv =====
// Package for the local alignment score and traceback unit.
// Holds shared constants and the input and result beat types; no dependencies.
package lsat_pkg;

  localparam int MAX_LENGTH_DEF = 16;
  localparam int SYM_W          = 8;
  localparam int SCORE_W        = 10;
  localparam int IDX_W          = 7;
  localparam int CFG_DATA_W     = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int RESULT_LIMIT   = 32;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 10'd1023;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

  typedef struct packed {
    logic [SYM_W-1:0] first_symbol;
    logic [SYM_W-1:0] second_symbol;
    logic             final_pair;
  } in_beat_t;

  typedef struct packed {
    logic               record_kind;
    logic [SCORE_W-1:0] cell_score;
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   column_index;
    logic               overflow;
    logic               run_end;
  } out_beat_t;

endpackage

// ===== design/lsat_stream_if.sv =====
// Valid/ready channel interface carrying one payload beat.
// Depends on lsat_pkg only through the payload type given by the user.
interface lsat_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/local_alignment_score_traceback_unit.sv =====
// Local alignment (linear gap) score matrix fill and traceback.
// Depends on lsat_pkg and lsat_stream_if.
//
//  Channel | Direction | Beat content
//  in_     | sink      | first_symbol, second_symbol, final_pair
//  out_    | source    | record_kind, cell_score, row/column index, overflow, run_end
//  cfg_    | write     | cfg_we, cfg_index, cfg_data (match, mismatch, gap)
//
// Loading takes one beat per cycle. After the final pair the matrix fill visits
// each of the n*n interior cells in row-major order through S_RD_D, S_RD_U,
// S_RD_L and S_WR, as the single-port score memory serves three neighbour reads
// and one write. Traceback passes each path cell through S_EMIT, S_T_RD_D/L/U
// and S_T_DEC, and S_EMIT waits on output stalls. Reset is synchronous; the border
// of the matrix is rewritten at each run start, so no clearing pass follows reset.
// The output register holds a beat while out_ready is low; the unit stalls.
// A path beat is not shown on the output until traceback knows whether it is
// the last one, so that its run_end flag is settled before it can leave.
module local_alignment_score_traceback_unit #(
  parameter int MAX_LENGTH = lsat_pkg::MAX_LENGTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lsat_stream_if.sink                     in_,
  lsat_stream_if.source                   out_,
  input  logic                            cfg_we,
  input  logic [lsat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsat_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsat_pkg::*;

  localparam int DIM   = MAX_LENGTH + 1;
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int SEQ_A = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int MEM_D = DIM * DIM;
  localparam int MEM_A = $clog2(MEM_D);

  typedef enum logic [3:0] {
    S_LOAD, S_BORDER, S_RD_D, S_RD_U, S_RD_L, S_WR,
    S_BEST, S_T_RD_D, S_T_RD_L, S_T_RD_U, S_T_DEC, S_EMIT
  } state_t;

  // Configuration registers.
  logic [3:0] match_r;
  logic signed [4:0] mismatch_r, gap_r;

  // Memories: sequences and the score matrix.
  logic [SYM_W-1:0]   seq_a_mem [MAX_LENGTH];
  logic [SYM_W-1:0]   seq_b_mem [MAX_LENGTH];
  logic [SCORE_W-1:0] score_mem [MEM_D];

  state_t state_r;
  logic [CNT_W-1:0] n_r;
  logic             ovf_r;
  logic [CNT_W-1:0] row_r, col_r;
  logic [SCORE_W-1:0] best_r;
  logic [CNT_W-1:0] best_row_r, best_col_r;
  logic [SCORE_W-1:0] d_r, u_r, l_r;
  logic [SYM_W-1:0] sa_r, sb_r;
  logic [5:0] cnt_r;           // results emitted so far
  out_beat_t out_r;
  logic out_valid_r;

  // Memory access port.
  logic               mem_we;
  logic [MEM_A-1:0]   mem_addr;
  logic [SCORE_W-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) score_mem[mem_addr] <= mem_wdata;
    mem_rdata <= score_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (in_.valid && in_.ready && (n_r < CNT_W'(MAX_LENGTH))) begin
      seq_a_mem[n_r[SEQ_A-1:0]] <= in_.data.first_symbol;
      seq_b_mem[n_r[SEQ_A-1:0]] <= in_.data.second_symbol;
    end
    sa_r <= seq_a_mem[SEQ_A'(row_r - CNT_W'(1))];
    sb_r <= seq_b_mem[SEQ_A'(col_r - CNT_W'(1))];
  end

  function automatic logic [MEM_A-1:0] addr_of(input logic [CNT_W-1:0] r,
                                               input logic [CNT_W-1:0] c);
    addr_of = MEM_A'(r * DIM + c);
  endfunction

  // Fill arithmetic: one candidate compare chain on 12-bit signed values.
  logic signed [11:0] dg, ug, lg, vmax;
  logic [SCORE_W-1:0] cell_v;
  always_comb begin
    dg = $signed({2'b00, d_r}) + ((sa_r == sb_r) ? $signed({8'd0, match_r})
                                               : 12'(mismatch_r));
    ug = $signed({2'b00, u_r}) + 12'(gap_r);
    lg = $signed({2'b00, mem_rdata}) + 12'(gap_r);
    vmax = 12'sd0;
    if (dg > vmax) vmax = dg;
    if (ug > vmax) vmax = ug;
    if (lg > vmax) vmax = lg;
    cell_v = (vmax > 12'sd1023) ? SCORE_MAX : vmax[SCORE_W-1:0];
  end

  // Traceback choice: diagonal, then left, then up.
  logic [SCORE_W-1:0] tmax;
  always_comb begin
    tmax = d_r;
    if (l_r > tmax) tmax = l_r;
    if (mem_rdata > tmax) tmax = mem_rdata;
  end

  // The last path beat may not leave before traceback decides it is last.
  logic hold_last;
  assign hold_last = (state_r == S_T_RD_D) || (state_r == S_T_RD_L) ||
                     (state_r == S_T_RD_U) || (state_r == S_T_DEC);

  // A path beat is the last one when it reaches the border or the result limit.
  logic emit_last;
  assign emit_last = (row_r == '0) || (col_r == '0) ||
                     (cnt_r + 6'd1 == 6'(RESULT_LIMIT));

  logic out_free;
  logic out_load;
  assign out_free = !out_valid_r || out_.ready;
  assign out_load = out_free && ((state_r == S_BEST) || (state_r == S_EMIT));
  assign in_.ready = (state_r == S_LOAD);
  assign out_.valid = out_valid_r && !hold_last;
  assign out_.data  = out_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wdata = '0;
    mem_addr = addr_of(row_r, col_r);
    unique case (state_r)
      S_BORDER: begin
        mem_we = 1'b1;
        mem_addr = (col_r == '0) ? addr_of(row_r, '0) : addr_of('0, col_r);
      end
      S_RD_D:   mem_addr = addr_of(row_r - CNT_W'(1), col_r - CNT_W'(1));
      S_RD_U:   mem_addr = addr_of(row_r - CNT_W'(1), col_r);
      S_RD_L:   mem_addr = addr_of(row_r, col_r - CNT_W'(1));
      S_WR: begin
        mem_we = 1'b1;
        mem_wdata = cell_v;
      end
      S_T_RD_D: mem_addr = addr_of(row_r - CNT_W'(1), col_r - CNT_W'(1));
      S_T_RD_L: mem_addr = addr_of(row_r, col_r - CNT_W'(1));
      S_T_RD_U: mem_addr = addr_of(row_r - CNT_W'(1), col_r);
      default:  mem_addr = addr_of(row_r, col_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 4'd2;
      mismatch_r <= -5'sd1;
      gap_r <= -5'sd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MATCH:    match_r <= cfg_data[3:0];
        CFG_MISMATCH: mismatch_r <= cfg_data;
        CFG_GAP:      gap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      n_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
      row_r <= '0;
      col_r <= '0;
      best_r <= '0;
      best_row_r <= '0;
      best_col_r <= '0;
      cnt_r <= '0;
    end else begin
      if (out_.valid && out_.ready && !out_load) out_valid_r <= 1'b0;
      unique case (state_r)
        S_LOAD: if (in_.valid) begin
          if (n_r < CNT_W'(MAX_LENGTH)) n_r <= n_r + CNT_W'(1);
          else ovf_r <= 1'b1;
          if (in_.data.final_pair) begin
            row_r <= '0;
            col_r <= '0;
            best_r <= '0;
            best_row_r <= '0;
            best_col_r <= '0;
            state_r <= S_BORDER;
          end
        end
        // Border sweep: row index 0..n in column 0, then column 1..n in row 0.
        S_BORDER: begin
          if (col_r == '0 && row_r != n_r) row_r <= row_r + CNT_W'(1);
          else if (col_r == '0) begin
            row_r <= '0;
            col_r <= CNT_W'(1);
            if (n_r == CNT_W'(0)) state_r <= S_BEST;
          end else if (col_r != n_r) col_r <= col_r + CNT_W'(1);
          else begin
            row_r <= CNT_W'(1);
            col_r <= CNT_W'(1);
            state_r <= S_RD_D;
          end
        end
        S_RD_D: state_r <= S_RD_U;
        S_RD_U: begin
          d_r <= mem_rdata;
          state_r <= S_RD_L;
        end
        S_RD_L: begin
          u_r <= mem_rdata;
          state_r <= S_WR;
        end
        S_WR: begin
          if (cell_v > best_r) begin
            best_r <= cell_v;
            best_row_r <= row_r;
            best_col_r <= col_r;
          end
          if (col_r != n_r) begin
            col_r <= col_r + CNT_W'(1);
            state_r <= S_RD_D;
          end else if (row_r != n_r) begin
            col_r <= CNT_W'(1);
            row_r <= row_r + CNT_W'(1);
            state_r <= S_RD_D;
          end else state_r <= S_BEST;
        end
        S_BEST: if (out_free) begin
          out_valid_r <= 1'b1;
          out_r <= '{record_kind: 1'b0, cell_score: best_r,
                     row_index: IDX_W'(best_row_r), column_index: IDX_W'(best_col_r),
                     overflow: ovf_r, run_end: 1'b0};
          row_r <= best_row_r;
          col_r <= best_col_r;
          l_r <= best_r;       // carries the start cell score
          cnt_r <= 6'd1;
          state_r <= S_EMIT;
        end
        S_EMIT: if (out_free) begin
          // l_r holds the score of the cell at (row_r, col_r).
          out_valid_r <= 1'b1;
          out_r <= '{record_kind: 1'b1, cell_score: l_r,
                     row_index: IDX_W'(row_r), column_index: IDX_W'(col_r),
                     overflow: ovf_r, run_end: emit_last};
          cnt_r <= cnt_r + 6'd1;
          if (emit_last) begin
            state_r <= S_LOAD;
            n_r <= '0;
            ovf_r <= 1'b0;
          end else state_r <= S_T_RD_D;
        end
        S_T_RD_D: state_r <= S_T_RD_L;
        S_T_RD_L: begin
          d_r <= mem_rdata;
          state_r <= S_T_RD_U;
        end
        S_T_RD_U: begin
          l_r <= mem_rdata;
          state_r <= S_T_DEC;
        end
        S_T_DEC: begin
          if (tmax == '0) begin
            // Path ends: mark the beat already held as the last one.
            out_r.run_end <= 1'b1;
            out_valid_r <= 1'b1;
            state_r <= S_LOAD;
            n_r <= '0;
            ovf_r <= 1'b0;
          end else begin
            if (tmax == d_r) begin
              row_r <= row_r - CNT_W'(1);
              col_r <= col_r - CNT_W'(1);
            end else if (tmax == l_r) col_r <= col_r - CNT_W'(1);
            else row_r <= row_r - CNT_W'(1);
            l_r <= tmax;
            state_r <= S_EMIT;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_.valid && !out_.ready |=> out_.valid && $stable(out_r))
    else $error("result beat changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (row_r != '0) && (col_r != '0) &&
                          (row_r <= n_r) && (col_r <= n_r))
    else $error("fill outside the matrix");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_.ready |-> !hold_last)
    else $error("input accepted during traceback");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r < 6'(RESULT_LIMIT)))
    else $error("result limit exceeded");

endmodule
